// File: src/vna_pkg.sv
// ----------------------------------------------------------------------------
// vna_pkg
// shared types and constants for the vertex normal accumulator
// ----------------------------------------------------------------------------
`default_nettype none

package vna_pkg;

    localparam int VERTEX_DEPTH = 1024;
    localparam int IDX_W        = $clog2(VERTEX_DEPTH);
    localparam int POS_W        = 16;
    localparam int SUM_W        = 48;
    localparam int FACE_W       = 35;
    localparam int NRM_W        = 16;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_TRI   = 2'd1,
        KIND_READ  = 2'd2,
        KIND_NONE  = 2'd3
    } vna_kind_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_POS_A,
        ST_POS_B,
        ST_POS_C,
        ST_POS_CAP,
        ST_DIFF,
        ST_CROSS,
        ST_SUM_RD,
        ST_SUM_WR,
        ST_RD_ISSUE,
        ST_RD_CAP,
        ST_SHIFT,
        ST_SQUARE,
        ST_SQRT,
        ST_DIV_INIT,
        ST_DIV,
        ST_OUT
    } vna_state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [9:0]  index_a;
        logic [9:0]  index_b;
        logic [9:0]  index_c;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
    } vna_in_t;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic               normal_valid;
    } vna_out_t;

endpackage

`default_nettype wire

// File: src/vertex_normal_accumulator.sv
// ----------------------------------------------------------------------------
// vertex_normal_accumulator
// area weighted vertex normals: position store, saturating normal sums,
// normalization through one shared multiplier, shift-subtract root and divide
// ----------------------------------------------------------------------------
// load: position stored and sum cleared in the idle state; triangle: three position reads, six products
//   through the shared multiplier, three sum read-modify-writes
// read: up to 17 shift steps, 32 root steps and one divide per component; a zero sum
//   skips the divides, and a result waits for an earlier one to be taken
// one item at a time; s_ready is high only while the sequencer is idle
// reset: a pass over all 1024 entries clears the normal sums before the first transfer
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_normal_accumulator
    import vna_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire vna_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output vna_out_t      m_data
);

    vna_state_t state_reg, state_next;

    vna_in_t            item_reg;
    logic [IDX_W-1:0]   clr_reg;
    logic [2:0]         step_reg;
    logic [4:0]         iter_reg;

    logic [3*POS_W-1:0] pos_mem [VERTEX_DEPTH];
    logic [3*SUM_W-1:0] sum_mem [VERTEX_DEPTH];
    logic [3*POS_W-1:0] pos_q_reg;
    logic [3*SUM_W-1:0] sum_q_reg;

    logic signed [POS_W-1:0]  pa_reg [3];
    logic signed [POS_W-1:0]  pb_reg [3];
    logic signed [POS_W-1:0]  pc_reg [3];
    logic signed [POS_W:0]    u_reg [3];
    logic signed [POS_W:0]    w_reg [3];
    logic signed [63:0]       prod_reg;
    logic signed [63:0]       tmp_reg;
    logic signed [FACE_W-1:0] f_reg [3];

    logic [SUM_W-1:0] mag_reg [3];
    logic [2:0]       neg_reg;
    logic [63:0]      x_reg;
    logic [63:0]      r_reg;
    logic [63:0]      bit_reg;
    logic [47:0]      rem_reg;
    logic [47:0]      div_reg;
    logic [15:0]      q_reg;
    logic             zero_reg;
    logic [NRM_W-1:0] nrm_reg [3];

    logic             m_valid_reg;
    vna_out_t         m_data_reg;

    logic             s_fire;
    logic             out_free;
    logic [IDX_W-1:0] idx_a, idx_b, idx_c, corner_idx;

    logic                pos_we;
    logic [IDX_W-1:0]    pos_addr;
    logic                sum_we;
    logic [IDX_W-1:0]    sum_waddr;
    logic [3*SUM_W-1:0]  sum_wdata;
    logic                sum_re;
    logic [IDX_W-1:0]    sum_raddr;

    logic signed [32:0]  mul_a, mul_b;
    logic signed [65:0]  mul_p;

    logic [SUM_W-1:0]    sat_out [3];
    logic [63:0]         sq_trial;
    logic                sq_ge;
    logic                div_ge;
    logic [15:0]         q_new;
    logic [NRM_W-1:0]    q_signed;
    logic                any_big;

    assign idx_a = item_reg.index_a[IDX_W-1:0];
    assign idx_b = item_reg.index_b[IDX_W-1:0];
    assign idx_c = item_reg.index_c[IDX_W-1:0];

    always_comb begin
        unique case (step_reg)
            3'd0:    corner_idx = idx_a;
            3'd1:    corner_idx = idx_b;
            default: corner_idx = idx_c;
        endcase
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_CROSS) begin
            unique case (step_reg)
                3'd0: begin mul_a = 33'(u_reg[1]); mul_b = 33'(w_reg[2]); end
                3'd1: begin mul_a = 33'(u_reg[2]); mul_b = 33'(w_reg[1]); end
                3'd2: begin mul_a = 33'(u_reg[2]); mul_b = 33'(w_reg[0]); end
                3'd3: begin mul_a = 33'(u_reg[0]); mul_b = 33'(w_reg[2]); end
                3'd4: begin mul_a = 33'(u_reg[0]); mul_b = 33'(w_reg[1]); end
                3'd5: begin mul_a = 33'(u_reg[1]); mul_b = 33'(w_reg[0]); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end else if (state_reg == ST_SQUARE) begin
            unique case (step_reg)
                3'd0:    mul_a = $signed({1'b0, mag_reg[0][31:0]});
                3'd1:    mul_a = $signed({1'b0, mag_reg[1][31:0]});
                default: mul_a = $signed({1'b0, mag_reg[2][31:0]});
            endcase
            mul_b = mul_a;
        end
    end
    assign mul_p = mul_a * mul_b;

    // saturating sum update
    always_comb begin
        logic signed [SUM_W:0] t;
        for (int i = 0; i < 3; i++) begin
            t = $signed({sum_q_reg[i*SUM_W + SUM_W-1], sum_q_reg[i*SUM_W +: SUM_W]})
                + (SUM_W+1)'(f_reg[i]);
            if (t[SUM_W] != t[SUM_W-1]) begin
                sat_out[i] = t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                      : {1'b0, {(SUM_W-1){1'b1}}};
            end else begin
                sat_out[i] = t[SUM_W-1:0];
            end
        end
    end

    assign sq_trial = r_reg + bit_reg;
    assign sq_ge    = (x_reg >= sq_trial);
    assign div_ge   = (rem_reg >= div_reg);
    assign q_new    = {q_reg[14:0], div_ge};
    assign q_signed = neg_reg[step_reg[1:0]] ? NRM_W'(-q_new) : q_new;
    assign any_big  = (|mag_reg[0][SUM_W-1:31]) || (|mag_reg[1][SUM_W-1:31])
                      || (|mag_reg[2][SUM_W-1:31]);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:    if (clr_reg == IDX_W'(VERTEX_DEPTH-1)) state_next = ST_IDLE;
            ST_IDLE: begin
                if (s_fire) begin
                    unique case (s_data.kind)
                        KIND_TRI:  state_next = ST_POS_A;
                        KIND_READ: state_next = ST_RD_ISSUE;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_POS_A:    state_next = ST_POS_B;
            ST_POS_B:    state_next = ST_POS_C;
            ST_POS_C:    state_next = ST_POS_CAP;
            ST_POS_CAP:  state_next = ST_DIFF;
            ST_DIFF:     state_next = ST_CROSS;
            ST_CROSS:    if (step_reg == 3'd6) state_next = ST_SUM_RD;
            ST_SUM_RD:   state_next = ST_SUM_WR;
            ST_SUM_WR:   state_next = (step_reg == 3'd2) ? ST_IDLE : ST_SUM_RD;
            ST_RD_ISSUE: state_next = ST_RD_CAP;
            ST_RD_CAP:   state_next = ST_SHIFT;
            ST_SHIFT:    if (!any_big) state_next = ST_SQUARE;
            ST_SQUARE:   if (step_reg == 3'd3) state_next = ST_SQRT;
            ST_SQRT:     if (iter_reg == 5'd31) state_next = ST_DIV_INIT;
            ST_DIV_INIT: state_next = (r_reg == '0) ? ST_OUT : ST_DIV;
            ST_DIV: begin
                if (iter_reg == 5'd15) begin
                    state_next = (step_reg == 3'd2) ? ST_OUT : ST_DIV_INIT;
                end
            end
            ST_OUT:      if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        pos_we    = 1'b0;
        pos_addr  = idx_a;
        sum_we    = 1'b0;
        sum_waddr = corner_idx;
        sum_wdata = {sat_out[2], sat_out[1], sat_out[0]};
        sum_re    = 1'b0;
        sum_raddr = corner_idx;
        unique case (state_reg)
            ST_CLEAR: begin
                sum_we    = 1'b1;
                sum_waddr = clr_reg;
                sum_wdata = '0;
            end
            ST_IDLE: begin
                pos_addr = s_data.index_a[IDX_W-1:0];
                if (s_fire && s_data.kind == KIND_LOAD) begin
                    pos_we    = 1'b1;
                    sum_we    = 1'b1;
                    sum_waddr = s_data.index_a[IDX_W-1:0];
                    sum_wdata = '0;
                end
            end
            ST_POS_A:    pos_addr = idx_a;
            ST_POS_B:    pos_addr = idx_b;
            ST_POS_C:    pos_addr = idx_c;
            ST_SUM_RD:   sum_re = 1'b1;
            ST_SUM_WR:   sum_we = 1'b1;
            ST_RD_ISSUE: begin
                sum_re    = 1'b1;
                sum_raddr = idx_a;
            end
            default: begin
                pos_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (pos_we) begin
            pos_mem[pos_addr] <= {s_data.pos_z, s_data.pos_y, s_data.pos_x};
        end
        pos_q_reg <= pos_mem[pos_addr];
    end

    always_ff @(posedge aclk) begin
        if (sum_we) begin
            sum_mem[sum_waddr] <= sum_wdata;
        end
        if (sum_re) begin
            sum_q_reg <= sum_mem[sum_raddr];
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            step_reg    <= '0;
            iter_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_reg <= clr_reg + 1'b1;
            end
            unique case (state_reg)
                ST_DIFF, ST_SUM_WR, ST_RD_CAP, ST_IDLE: begin
                    if (state_reg == ST_SUM_WR) begin
                        step_reg <= step_reg + 1'b1;
                    end else begin
                        step_reg <= '0;
                    end
                end
                ST_CROSS:  step_reg <= (step_reg == 3'd6) ? 3'd0 : step_reg + 1'b1;
                ST_SQUARE: step_reg <= (step_reg == 3'd3) ? 3'd0 : step_reg + 1'b1;
                ST_DIV:    if (iter_reg == 5'd15) step_reg <= step_reg + 1'b1;
                default:   step_reg <= step_reg;
            endcase
            unique case (state_reg)
                ST_SQRT: iter_reg <= iter_reg + 1'b1;
                ST_DIV:  iter_reg <= (iter_reg == 5'd15) ? 5'd0 : iter_reg + 1'b1;
                default: iter_reg <= '0;
            endcase
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_reg <= s_data;
        end
        unique case (state_reg)
            ST_POS_B: begin
                for (int i = 0; i < 3; i++) pa_reg[i] <= pos_q_reg[i*POS_W +: POS_W];
            end
            ST_POS_C: begin
                for (int i = 0; i < 3; i++) pb_reg[i] <= pos_q_reg[i*POS_W +: POS_W];
            end
            ST_POS_CAP: begin
                for (int i = 0; i < 3; i++) pc_reg[i] <= pos_q_reg[i*POS_W +: POS_W];
            end
            ST_DIFF: begin
                for (int i = 0; i < 3; i++) begin
                    u_reg[i] <= (POS_W+1)'(pb_reg[i]) - (POS_W+1)'(pa_reg[i]);
                    w_reg[i] <= (POS_W+1)'(pc_reg[i]) - (POS_W+1)'(pa_reg[i]);
                end
            end
            ST_CROSS: begin
                prod_reg <= mul_p[63:0];
                if (step_reg != 3'd0) begin
                    if (step_reg[0]) begin
                        tmp_reg <= prod_reg;
                    end else begin
                        f_reg[step_reg[2:1] - 2'd1] <= FACE_W'(tmp_reg - prod_reg);
                    end
                end
            end
            ST_RD_CAP: begin
                for (int i = 0; i < 3; i++) begin
                    neg_reg[i] <= sum_q_reg[i*SUM_W + SUM_W-1];
                    mag_reg[i] <= sum_q_reg[i*SUM_W + SUM_W-1]
                                  ? SUM_W'(-sum_q_reg[i*SUM_W +: SUM_W])
                                  : sum_q_reg[i*SUM_W +: SUM_W];
                end
                x_reg <= '0;
            end
            ST_SHIFT: begin
                if (any_big) begin
                    for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] >> 1;
                end
            end
            ST_SQUARE: begin
                prod_reg <= mul_p[63:0];
                if (step_reg != 3'd0) begin
                    x_reg <= x_reg + prod_reg;
                end
                r_reg   <= '0;
                bit_reg <= 64'd1 << 62;
            end
            ST_SQRT: begin
                if (sq_ge) begin
                    x_reg <= x_reg - sq_trial;
                    r_reg <= (r_reg >> 1) + bit_reg;
                end else begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            ST_DIV_INIT: begin
                zero_reg <= (r_reg == '0);
                rem_reg  <= ({17'd0, mag_reg[step_reg[1:0]][30:0]} << 14)
                            + {16'd0, r_reg[32:1]};
                div_reg  <= {r_reg[32:0], 15'd0};
                q_reg    <= '0;
            end
            ST_DIV: begin
                if (div_ge) begin
                    rem_reg <= rem_reg - div_reg;
                end
                div_reg <= div_reg >> 1;
                q_reg   <= q_new;
                if (iter_reg == 5'd15) begin
                    nrm_reg[step_reg[1:0]] <= q_signed;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_data_reg.normal_x     <= zero_reg ? '0 : $signed(nrm_reg[0]);
                    m_data_reg.normal_y     <= zero_reg ? '0 : $signed(nrm_reg[1]);
                    m_data_reg.normal_z     <= zero_reg ? '0 : $signed(nrm_reg[2]);
                    m_data_reg.normal_valid <= !zero_reg;
                end
            end
            default: begin
                tmp_reg <= tmp_reg;
            end
        endcase
    end

    // checks
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_OUT))
        else $error("result appeared outside the output step");

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> !s_ready)
        else $error("input ready during clearing pass");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.normal_valid |->
            m_data.normal_x == '0 && m_data.normal_y == '0 && m_data.normal_z == '0)
        else $error("zero sum returned a nonzero normal");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.normal_x <= 16'sd16384 && m_data.normal_x >= -16'sd16384
                 && m_data.normal_y <= 16'sd16384 && m_data.normal_y >= -16'sd16384
                 && m_data.normal_z <= 16'sd16384 && m_data.normal_z >= -16'sd16384)
        else $error("normal component beyond unit range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("pending transfer dropped");

endmodule

`default_nettype wire

// File: tb/vertex_normal_accumulator_test.sv
// ----------------------------------------------------------------------------
// vertex_normal_accumulator_test
// drives load, triangle, read and no-op transfers under several idling phases and
// checks every read result against a predictor of the normalized vertex sums
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_normal_accumulator_test
    import vna_pkg::*;
;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    vna_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    vna_out_t m_data;

    vertex_normal_accumulator DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        aclk = 1'b1; #6;
        aclk = 1'b0; #6;
    end

    localparam longint SUM_HI = 64'sh7FFF_FFFF_FFFF;
    localparam longint SUM_LO = -SUM_HI - 1;

    longint   vpos [VERTEX_DEPTH][3];
    bit       vloaded [VERTEX_DEPTH];
    longint   nsum [VERTEX_DEPTH][3];
    vna_in_t  pending_items[$];
    vna_out_t expected_normals[$];
    int       send_idle_pct;
    int       recv_stall_pct;
    int       errors;
    int       reads_checked;
    int       tris_sent;
    bit       hold_sender;
    bit       in_taken;

    function automatic longint clamp_add(longint s, longint f);
        longint r;
        r = s + f;
        if (r > SUM_HI) return SUM_HI;
        if (r < SUM_LO) return SUM_LO;
        return r;
    endfunction

    function automatic longint int_root(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic vna_out_t unit_normal(int v);
        vna_out_t o;
        longint unsigned mag [3];
        longint unsigned m;
        longint unsigned l2;
        longint unsigned len;
        longint q;
        int k;
        m = 0;
        l2 = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = nsum[v][i] < 0 ? -nsum[v][i] : nsum[v][i];
            if (mag[i] > m) m = mag[i];
        end
        k = 0;
        while ((m >> k) >= (64'd1 << 31)) k++;
        for (int i = 0; i < 3; i++) begin
            mag[i] >>= k;
            l2 += mag[i] * mag[i];
        end
        len = int_root(l2);
        o = '0;
        if (len == 0) return o;
        for (int i = 0; i < 3; i++) begin
            q = longint'((mag[i] * 16384 + len / 2) / len);
            if (nsum[v][i] < 0) q = -q;
            case (i)
                0: o.normal_x = q[15:0];
                1: o.normal_y = q[15:0];
                default: o.normal_z = q[15:0];
            endcase
        end
        o.normal_valid = 1'b1;
        return o;
    endfunction

    // update the mesh state for one accepted transfer
    function automatic void apply_item(vna_in_t it);
        int a, b, c;
        longint u [3];
        longint w [3];
        longint f [3];
        int cr [3];
        a = int'(it.index_a);
        b = int'(it.index_b);
        c = int'(it.index_c);
        case (vna_kind_t'(it.kind))
            KIND_LOAD: begin
                vpos[a][0] = longint'(it.pos_x);
                vpos[a][1] = longint'(it.pos_y);
                vpos[a][2] = longint'(it.pos_z);
                for (int i = 0; i < 3; i++) nsum[a][i] = 0;
            end
            KIND_TRI: begin
                for (int i = 0; i < 3; i++) begin
                    u[i] = vpos[b][i] - vpos[a][i];
                    w[i] = vpos[c][i] - vpos[a][i];
                end
                f[0] = u[1] * w[2] - u[2] * w[1];
                f[1] = u[2] * w[0] - u[0] * w[2];
                f[2] = u[0] * w[1] - u[1] * w[0];
                cr[0] = a; cr[1] = b; cr[2] = c;
                for (int j = 0; j < 3; j++)
                    for (int i = 0; i < 3; i++)
                        nsum[cr[j]][i] = clamp_add(nsum[cr[j]][i], f[i]);
            end
            KIND_READ: expected_normals = {expected_normals, unit_normal(a)};
            default: ;
        endcase
    endfunction

    // driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !in_taken) begin
            s_valid <= 1'b1;
        end else if (pending_items.size() > 0 && !hold_sender
                     && $urandom_range(99) >= send_idle_pct) begin
            s_valid <= 1'b1;
            s_data  <= pending_items.pop_front();
        end else begin
            s_valid <= 1'b0;
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor
    always @(posedge aclk) begin
        in_taken = aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            apply_item(s_data);
            if (s_data.kind == KIND_TRI) tris_sent++;
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_normals.size() == 0) begin
                $error("unexpected result transfer");
                errors++;
            end else begin
                vna_out_t e;
                e = expected_normals.pop_front();
                reads_checked++;
                if (m_data.normal_x !== e.normal_x) begin
                    $error("normal_x exp %0d got %0d", e.normal_x, m_data.normal_x);
                    errors++;
                end
                if (m_data.normal_y !== e.normal_y) begin
                    $error("normal_y exp %0d got %0d", e.normal_y, m_data.normal_y);
                    errors++;
                end
                if (m_data.normal_z !== e.normal_z) begin
                    $error("normal_z exp %0d got %0d", e.normal_z, m_data.normal_z);
                    errors++;
                end
                if (m_data.normal_valid !== e.normal_valid) begin
                    $error("normal_valid exp %0d got %0d", e.normal_valid,
                           m_data.normal_valid);
                    errors++;
                end
            end
        end
    end

    function automatic vna_in_t make_item(vna_kind_t k, int a, int b, int c,
                                          int x, int y, int z);
        vna_in_t it;
        it.kind    = k;
        it.index_a = 10'(a);
        it.index_b = 10'(b);
        it.index_c = 10'(c);
        it.pos_x   = 16'(x);
        it.pos_y   = 16'(y);
        it.pos_z   = 16'(z);
        return it;
    endfunction

    // queue one item, marking its vertex as loaded when it is a load
    task automatic queue_item(vna_in_t it);
        pending_items = {pending_items, it};
        if (it.kind == KIND_LOAD) vloaded[it.index_a] = 1'b1;
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || s_valid || expected_normals.size() > 0)
            @(posedge aclk);
    endtask

    // random mesh work confined to a small window of vertices
    task automatic random_burst(int count);
        int base, span, a, b, c, r;
        int big;
        base = $urandom_range(VERTEX_DEPTH - 16);
        span = $urandom_range(15, 3);
        big = $urandom_range(1);
        for (int n = 0; n < count; n++) begin
            a = base + $urandom_range(span);
            b = base + $urandom_range(span);
            c = base + $urandom_range(span);
            r = $urandom_range(99);
            if (!vloaded[a] || r < 20) begin
                if (big)
                    queue_item(make_item(KIND_LOAD, a, $urandom, $urandom,
                        $urandom, $urandom, $urandom));
                else
                    queue_item(make_item(KIND_LOAD, a, $urandom, $urandom,
                        $urandom_range(2047) - 1024, $urandom_range(2047) - 1024,
                        $urandom_range(2047) - 1024));
            end else if (r < 60 && vloaded[b] && vloaded[c]) begin
                queue_item(make_item(KIND_TRI, a, b, c, $urandom, $urandom, $urandom));
            end else if (r < 95) begin
                queue_item(make_item(KIND_READ, a, $urandom, $urandom,
                    $urandom, $urandom, $urandom));
            end else begin
                queue_item(make_item(KIND_NONE, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom));
            end
        end
    endtask

    initial begin
        errors = 0;
        reads_checked = 0;
        tris_sent = 0;
        hold_sender = 1'b0;
        in_taken = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        for (int i = 0; i < VERTEX_DEPTH; i++) begin
            vloaded[i] = 1'b0;
            for (int j = 0; j < 3; j++) begin
                vpos[i][j] = 0;
                nsum[i][j] = 0;
            end
        end
        aresetn = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: extremes, zero sums, repeated corners, kind 3
        queue_item(make_item(KIND_READ, 1023, 0, 0, 0, 0, 0));
        queue_item(make_item(KIND_LOAD, 0, 0, 0, -32768, -32768, -32768));
        queue_item(make_item(KIND_LOAD, 1, 0, 0, 32767, -32768, -32768));
        queue_item(make_item(KIND_LOAD, 2, 0, 0, -32768, 32767, -32768));
        queue_item(make_item(KIND_LOAD, 1023, 1023, 1023, 32767, 32767, 32767));
        queue_item(make_item(KIND_TRI, 0, 1, 2, 0, 0, 0));
        queue_item(make_item(KIND_READ, 0, 0, 0, 0, 0, 0));
        queue_item(make_item(KIND_TRI, 0, 0, 1, 0, 0, 0));
        queue_item(make_item(KIND_READ, 1023, 0, 0, 0, 0, 0));
        queue_item(make_item(KIND_TRI, 1023, 1, 2, 0, 0, 0));
        queue_item(make_item(KIND_READ, 1023, 0, 0, 0, 0, 0));
        queue_item(make_item(KIND_READ, 2, 0, 0, 0, 0, 0));
        queue_item(make_item(KIND_NONE, 1023, 1023, 1023, -1, -1, -1));
        for (int i = 0; i < 8; i++)
            queue_item(make_item(KIND_TRI, 0, 1, 2, 0, 0, 0));
        queue_item(make_item(KIND_READ, 0, 0, 0, 0, 0, 0));
        queue_item(make_item(KIND_READ, 1, 0, 0, 0, 0, 0));
        wait_drained();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                3: begin send_idle_pct = 35; recv_stall_pct = 35; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int blk = 0; blk < 12; blk++) begin
                random_burst(20);
                while (pending_items.size() > 10) @(posedge aclk);
            end
            // sender holds off until every outstanding read has returned
            hold_sender = 1'b1;
            while (s_valid || expected_normals.size() > 0) @(posedge aclk);
            hold_sender = 1'b0;
        end

        wait_drained();
        repeat (150) @(posedge aclk);
        $display("checked %0d read results after %0d triangle transfers", reads_checked,
                 tris_sent);
        $display("covered extreme positions, zero sums, repeated corners and five idling phases");
        if (errors == 0)
            $display("vertex_normal_accumulator test passed");
        else
            $display("vertex_normal_accumulator test failed");
        $finish;
    end

    initial begin
        #30000000;
        $display("vertex_normal_accumulator test failed");
        $finish;
    end

endmodule

`default_nettype wire
